@@ rtl/core/phpd_pkg.sv @@
// Package for the piezo hit peak detector.
// Holds time and register widths, register index codes and reset values.
// No dependencies.
package phpd_pkg;

  localparam int TIME_BITS = 32;
  localparam int MS_BITS   = 16;
  localparam int CFG_BITS  = 16;

  typedef logic [TIME_BITS-1:0] time_ms_t;
  typedef logic [MS_BITS-1:0]   dur_ms_t;
  typedef logic [CFG_BITS-1:0]  cfg_data_t;

  typedef enum logic [1:0] {
    REG_HIT_THRESHOLD = 2'd0,
    REG_THROTTLE_MS   = 2'd1,
    REG_RETRIGGER_MS  = 2'd2,
    REG_WINDOW_MS     = 2'd3
  } cfg_reg_t;

  localparam int      RST_HIT_THRESHOLD = 50;
  localparam dur_ms_t RST_THROTTLE_MS   = 16'd0;
  localparam dur_ms_t RST_RETRIGGER_MS  = 16'd40;
  localparam dur_ms_t RST_WINDOW_MS     = 16'd3;

endpackage

@@ rtl/core/phpd_ifs.sv @@
// Valid/ready channel interfaces for the piezo hit peak detector.
// phpd_in_if carries sample transactions, phpd_out_if carries results.
// Depends on phpd_pkg.
interface phpd_in_if #(parameter int SAMPLE_BITS = 10);
  logic                       valid;
  logic                       ready;
  logic [SAMPLE_BITS-1:0]     sample;
  phpd_pkg::time_ms_t         now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface phpd_out_if #(parameter int SAMPLE_BITS = 10);
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [SAMPLE_BITS-1:0]     hit_velocity;
  logic [SAMPLE_BITS-1:0]     active_threshold;

  modport source (output valid, output hit, output hit_velocity, output active_threshold,
                  input ready);
  modport sink   (input valid, input hit, input hit_velocity, input active_threshold,
                  output ready);
endinterface

@@ rtl/core/piezo_hit_peak_detector.sv @@
// Piezo hit peak detector: input register, combinational hit logic, result register.
// The accepted input is held in the input register and moves on to the result register
// once that stage can advance, that is when the result register is empty or taken.
// Throughput: one transaction per cycle unless the result side stalls, set by the state update loop.
// Reset (rst_n, synchronous): clears both stages, window and hit state,
// and loads the register defaults. Depends on phpd_pkg and phpd_ifs.
module piezo_hit_peak_detector #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  phpd_in_if.sink               in_if,
  phpd_out_if.source            out_if,
  input  logic                  cfg_we,
  input  phpd_pkg::cfg_reg_t    cfg_index,
  input  phpd_pkg::cfg_data_t   cfg_data
);
  import phpd_pkg::*;

  localparam int DIV_SHIFT = SAMPLE_BITS + 1;
  localparam logic [SAMPLE_BITS:0] DIV3_MUL = (SAMPLE_BITS+1)'(((2 ** DIV_SHIFT) + 2) / 3);
  localparam int PROD_BITS = 2 * SAMPLE_BITS + 1;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  smp_t      thr_r;
  dur_ms_t   throttle_r;
  dur_ms_t   retrig_r;
  dur_ms_t   window_r;

  logic      s1_valid_r;
  smp_t      s1_sample_r;
  time_ms_t  s1_now_r;

  logic      win_open_r;
  time_ms_t  win_start_r;
  smp_t      peak_r;
  time_ms_t  last_time_r;
  smp_t      last_vel_r;

  logic      out_valid_r;
  logic      out_hit_r;
  smp_t      out_vel_r;
  smp_t      out_thr_r;

  logic                     s1_adv;
  logic                     s1_fire;
  logic                     in_fire;
  time_ms_t                 since_hit;
  logic [MS_BITS:0]         retrig_lim;
  logic [PROD_BITS-1:0]     div_prod;
  smp_t                     raised;
  smp_t                     level;
  logic                     above;
  logic                     win_open_mid;
  time_ms_t                 win_start_mid;
  smp_t                     peak_mid;
  time_ms_t                 win_age;
  logic                     emit;

  assign s1_adv      = !out_valid_r || out_if.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    since_hit     = s1_now_r - last_time_r;
    retrig_lim    = {1'b0, throttle_r} + {1'b0, retrig_r};
    div_prod      = {{(SAMPLE_BITS+1){1'b0}}, last_vel_r} * {{SAMPLE_BITS{1'b0}}, DIV3_MUL};
    raised        = div_prod[DIV_SHIFT +: SAMPLE_BITS];
    level         = thr_r;
    if ((since_hit <= {{(TIME_BITS-MS_BITS-1){1'b0}}, retrig_lim}) && (raised > thr_r)) begin
      level = raised;
    end
    above         = (since_hit >= {{(TIME_BITS-MS_BITS){1'b0}}, throttle_r}) &&
                    (s1_sample_r > level);
    win_open_mid  = win_open_r || above;
    win_start_mid = (!win_open_r && above) ? s1_now_r : win_start_r;
    peak_mid      = (above && (s1_sample_r > peak_r)) ? s1_sample_r : peak_r;
    win_age       = s1_now_r - win_start_mid;
    emit          = win_open_mid && (win_age >= {{(TIME_BITS-MS_BITS){1'b0}}, window_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= SAMPLE_BITS'(RST_HIT_THRESHOLD);
      throttle_r <= RST_THROTTLE_MS;
      retrig_r   <= RST_RETRIGGER_MS;
      window_r   <= RST_WINDOW_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIT_THRESHOLD: thr_r      <= cfg_data[SAMPLE_BITS-1:0];
        REG_THROTTLE_MS:   throttle_r <= cfg_data[MS_BITS-1:0];
        REG_RETRIGGER_MS:  retrig_r   <= cfg_data[MS_BITS-1:0];
        REG_WINDOW_MS:     window_r   <= cfg_data[MS_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_if.sample;
      s1_now_r    <= in_if.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_open_r  <= 1'b0;
      win_start_r <= '0;
      peak_r      <= '0;
      last_time_r <= '0;
      last_vel_r  <= '0;
    end else if (s1_fire) begin
      if (emit) begin
        win_open_r  <= 1'b0;
        peak_r      <= '0;
        last_time_r <= s1_now_r;
        last_vel_r  <= peak_mid;
      end else begin
        win_open_r  <= win_open_mid;
        peak_r      <= peak_mid;
      end
      win_start_r <= win_start_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_hit_r <= emit;
      out_vel_r <= emit ? peak_mid : '0;
      out_thr_r <= thr_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.hit              = out_hit_r;
  assign out_if.hit_velocity     = out_vel_r;
  assign out_if.active_threshold = out_thr_r;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_peak_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r != '0) |-> win_open_r)
    else $error("peak held with no open window");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit) |=> (!win_open_r && (peak_r == '0) && out_hit_r))
    else $error("window not cleared after emit");

  a_no_hit_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_vel_r == '0))
    else $error("velocity nonzero without hit");

  a_raised_bound: assert property (@(posedge clk) disable iff (!rst_n)
    raised <= last_vel_r)
    else $error("divide by three out of range");

endmodule

@@ tb/phpd_hit_checker.sv @@
// Checker for the piezo hit peak detector: watches the sample, result and
// register ports, predicts each result and compares it field by field.
// Depends on phpd_pkg and the channel interfaces in phpd_ifs.
module phpd_hit_checker #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  phpd_in_if                  mon_in,
  phpd_out_if                 mon_out,
  input  logic                cfg_we,
  input  phpd_pkg::cfg_reg_t  cfg_index,
  input  phpd_pkg::cfg_data_t cfg_data,
  output int unsigned         outstanding,
  output int unsigned         fail_count,
  output int unsigned         hit_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import phpd_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] level_t;

  typedef struct packed {
    logic   hit;
    level_t velocity;
    level_t threshold;
  } pad_result_t;

  level_t   base_thr;
  dur_ms_t  dead_ms;
  dur_ms_t  retrig_ms;
  dur_ms_t  win_ms;

  logic     win_open;
  time_ms_t win_start;
  level_t   peak;
  time_ms_t last_strike_t;
  level_t   last_vel;

  pad_result_t expected_hits[$];

  function automatic pad_result_t detect_strike(input level_t smp, input time_ms_t now);
    pad_result_t r;
    time_ms_t    since;
    time_ms_t    open_for;
    time_ms_t    guard;
    level_t      level;
    r     = '0;
    since = now - last_strike_t;
    guard = time_ms_t'(dead_ms) + time_ms_t'(retrig_ms);
    level = base_thr;
    if (since <= guard && level_t'(last_vel / 3) > level) begin
      level = level_t'(last_vel / 3);
    end
    if (since >= time_ms_t'(dead_ms) && smp > level) begin
      if (!win_open) begin
        win_open  = 1'b1;
        win_start = now;
      end
      if (smp > peak) begin
        peak = smp;
      end
    end
    open_for = now - win_start;
    if (win_open && open_for >= time_ms_t'(win_ms)) begin
      r.hit         = 1'b1;
      r.velocity    = peak;
      last_strike_t = now;
      last_vel      = peak;
      win_open      = 1'b0;
      peak          = '0;
    end
    r.threshold = base_thr;
    return r;
  endfunction

  always @(posedge clk) begin : track
    pad_result_t got;
    pad_result_t want;
    int          nerr;
    nerr = 0;
    if (!rst_n) begin
      base_thr      = level_t'(RST_HIT_THRESHOLD);
      dead_ms       = RST_THROTTLE_MS;
      retrig_ms     = RST_RETRIGGER_MS;
      win_ms        = RST_WINDOW_MS;
      win_open      = 1'b0;
      win_start     = '0;
      peak          = '0;
      last_strike_t = '0;
      last_vel      = '0;
      expected_hits.delete();
      outstanding <= 0;
      fail_count  <= 0;
      hit_count   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HIT_THRESHOLD: base_thr  = level_t'(cfg_data);
          REG_THROTTLE_MS:   dead_ms   = dur_ms_t'(cfg_data);
          REG_RETRIGGER_MS:  retrig_ms = dur_ms_t'(cfg_data);
          REG_WINDOW_MS:     win_ms    = dur_ms_t'(cfg_data);
          default: ;
        endcase
      end
      if (mon_out.valid && mon_out.ready) begin
        got.hit       = mon_out.hit;
        got.velocity  = mon_out.hit_velocity;
        got.threshold = mon_out.active_threshold;
        if (got.hit === 1'b1) begin
          hit_count <= hit_count + 1;
        end
        if (expected_hits.size() == 0) begin
          $error("result transaction with none expected: hit %0d velocity %0d threshold %0d",
                 got.hit, got.velocity, got.threshold);
          nerr++;
        end else begin
          want = expected_hits.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            nerr++;
          end
          if (got.velocity !== want.velocity) begin
            $error("hit_velocity: expected %0d, actual %0d", want.velocity, got.velocity);
            nerr++;
          end
          if (got.threshold !== want.threshold) begin
            $error("active_threshold: expected %0d, actual %0d", want.threshold, got.threshold);
            nerr++;
          end
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        expected_hits.push_back(detect_strike(mon_in.sample, mon_in.now_ms));
      end
      outstanding <= expected_hits.size();
      fail_count  <= fail_count + nerr;
    end
  end

endmodule

@@ tb/piezo_hit_peak_detector_tb.sv @@
// Top of the piezo hit peak detector testbench: clock, reset, sample and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on phpd_pkg, phpd_ifs, the detector RTL and phpd_hit_checker.
module piezo_hit_peak_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phpd_pkg::*;

  localparam int SB           = 10;
  localparam int RX_LONG_HOLD = 400;
  localparam int WATCHDOG     = 5000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 150;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_reg_t  cfg_index;
  cfg_data_t cfg_data;

  phpd_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  phpd_out_if #(.SAMPLE_BITS(SB)) out_if ();

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned hit_count;
  int unsigned quiet;
  int unsigned items_sent;
  int unsigned settings_loaded;
  logic [SB-1:0] cur_thr;
  bit tx_calm;
  bit rx_hold_req;

  piezo_hit_peak_detector #(.SAMPLE_BITS(SB)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  phpd_hit_checker #(.SAMPLE_BITS(SB)) hit_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .mon_in      (in_if),
    .mon_out     (out_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count),
    .hit_count   (hit_count)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom_range(0, 63);
    end else if (r < 55) begin
      v = int'(cur_thr) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end else if (r < 90) begin
      v = $urandom_range(0, 1023);
    end else begin
      v = $urandom_range(0, 1) ? 1023 : 0;
    end
    return v[SB-1:0];
  endfunction

  function automatic time_ms_t next_time(input time_ms_t t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return t + $urandom_range(0, 1);
    if (r < 85) return t + $urandom_range(2, 6);
    if (r < 95) return t + $urandom_range(7, 300);
    if (r < 98) return t + $urandom_range(30000, 140000);
    if (r < 99) return t - $urandom_range(1, 50);
    return $urandom;
  endfunction

  task automatic send_item(input logic [SB-1:0] s, input time_ms_t t);
    int gap;
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.now_ms <= t;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain(input int settle);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_config(input logic [SB-1:0] thr, input dur_ms_t dead,
                             input dur_ms_t retrig, input dur_ms_t win);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HIT_THRESHOLD;
    cfg_data  <= {6'($urandom), thr};
    @(posedge clk);
    cfg_index <= REG_THROTTLE_MS;
    cfg_data  <= dead;
    @(posedge clk);
    cfg_index <= REG_RETRIGGER_MS;
    cfg_data  <= retrig;
    @(posedge clk);
    cfg_index <= REG_WINDOW_MS;
    cfg_data  <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_thr = thr;
    settings_loaded++;
  endtask

  task automatic run_phase(input int n, input time_ms_t base, input bit rx_stall,
                           input bit mid_pause);
    time_ms_t t;
    t = base;
    for (int i = 0; i < n; i++) begin
      t = next_time(t);
      send_item(pick_sample(), t);
      if (rx_stall && i == n / 4) rx_hold_req = 1'b1;
      if (mid_pause && i == n / 2) drain(2);
    end
  endtask

  initial begin : rx_side
    int gap;
    int unsigned tick;
    gap  = 0;
    tick = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (RX_LONG_HOLD) @(posedge clk);
      end else if (gap > 0) begin
        out_if.ready <= 1'b0;
        gap--;
      end else begin
        out_if.ready <= 1'b1;
        if ((tick % 512) > 160 && $urandom_range(0, 3) == 0) gap = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [SB-1:0] thr;
    dur_ms_t dead;
    dur_ms_t retrig;
    dur_ms_t win;
    time_ms_t base;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_HIT_THRESHOLD;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.now_ms = '0;
    items_sent   = 0;
    settings_loaded = 0;
    cur_thr      = SB'(RST_HIT_THRESHOLD);
    tx_calm      = 1'b0;
    rx_hold_req  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: open, peak hold, raised threshold, wrap and backward jump
    send_item(10'd0, 32'd100);
    send_item(10'd1023, 32'd100);
    send_item(10'd500, 32'd101);
    send_item(10'd0, 32'd102);
    send_item(10'd0, 32'd103);
    send_item(10'd300, 32'd104);
    send_item(10'd342, 32'd105);
    send_item(10'd51, 32'd108);
    send_item(10'd60, 32'hFFFF_FFFE);
    send_item(10'd70, 32'h0000_0001);
    send_item(10'd100, 32'h0000_0000);
    send_item(10'd0, 32'd5);

    // zero window: open and emit on one sample
    drain(4);
    load_config(10'd60, 16'd0, 16'd40, 16'd0);
    send_item(10'd200, 32'd10);
    send_item(10'd61, 32'd11);
    send_item(10'd67, 32'd12);

    // top threshold: nothing can cross
    drain(4);
    load_config(10'd1023, 16'd0, 16'd0, 16'd1);
    send_item(10'd1023, 32'd20);

    // zero threshold, throttle, emit on a throttled sample
    drain(4);
    load_config(10'd0, 16'd10, 16'd0, 16'd5);
    send_item(10'd1, 32'd13);
    send_item(10'd300, 32'd25);
    send_item(10'd0, 32'd14);
    send_item(10'd1, 32'd40);
    send_item(10'd0, 32'd45);

    // widest durations
    drain(4);
    load_config(10'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(10'd1023, 32'd46);
    send_item(10'd1023, 32'd65581);
    send_item(10'd0, 32'd131116);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin thr = 10'd50;   dead = 16'd0;     retrig = 16'd40;    win = 16'd3;     end
        1: begin thr = 10'd0;    dead = 16'd0;     retrig = 16'd0;     win = 16'd0;     end
        2: begin thr = 10'd1023; dead = 16'hFFFF;  retrig = 16'hFFFF;  win = 16'hFFFF;  end
        3: begin thr = 10'd100;  dead = 16'd5;     retrig = 16'd30;    win = 16'd2;     end
        4: begin thr = 10'd200;  dead = 16'd0;     retrig = 16'hFFFF;  win = 16'd4;     end
        5: begin thr = 10'd30;   dead = 16'hFFFF;  retrig = 16'd0;     win = 16'd1;     end
        default: begin
          thr    = SB'($urandom_range(0, 400));
          dead   = dur_ms_t'($urandom_range(0, 8));
          retrig = dur_ms_t'($urandom_range(0, 100));
          win    = dur_ms_t'($urandom_range(0, 6));
        end
      endcase
      drain(4);
      load_config(thr, dead, retrig, win);
      tx_calm = (p % 3 == 1);
      base = (p == 1) ? 32'hFFFF_FF80 : time_ms_t'($urandom);
      run_phase(PHASE_ITEMS, base, p == 3, p == 4);
    end

    drain(8);
    $display("Covered %0d sample transactions under %0d register settings, %0d hits emitted.",
             items_sent, settings_loaded + 1, hit_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/phpd_pkg.sv
rtl/core/phpd_ifs.sv
rtl/core/piezo_hit_peak_detector.sv
tb/phpd_hit_checker.sv
tb/piezo_hit_peak_detector_tb.sv
